// ===== rtl/mcs_pkg.sv =====
package mcs_pkg;

  localparam int CLOCKS_PER_BEAT = 24;
  localparam int GAP_WIDTH       = 16;
  localparam int BEAT_WIDTH      = 21;
  localparam int TIMEOUT_WIDTH   = 16;
  localparam int CMP_WIDTH       = (GAP_WIDTH > TIMEOUT_WIDTH) ? GAP_WIDTH : TIMEOUT_WIDTH;
  localparam int CIB_WIDTH       = $clog2(CLOCKS_PER_BEAT + 1);
  localparam int SHIFT_MAX       = 4;
  localparam int SENT_WIDTH      = 5;
  localparam int SONG_WIDTH      = 14;
  localparam int TICK_WIDTH      = 32;
  localparam int REQ_WIDTH       = 8;

  localparam logic [GAP_WIDTH-1:0] GAP_MAX = '1;

  typedef enum logic [2:0] {
    OP_TIMER      = 3'd0,
    OP_MIDI       = 3'd1,
    OP_HOST       = 3'd2,
    OP_POLL_FLAGS = 3'd3,
    OP_POLL_CLOCK = 3'd4,
    OP_SET_TICK   = 3'd5,
    OP_AUTO_CHECK = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  localparam logic [1:0] MODE_MASTER = 2'd0;
  localparam logic [1:0] MODE_SLAVE  = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  localparam logic [1:0] HOST_START = 2'd0;
  localparam logic [1:0] HOST_CONT  = 2'd1;
  localparam logic [1:0] HOST_STOP  = 2'd2;

  localparam logic [1:0] CFG_CLOCK_MODE    = 2'd0;
  localparam logic [1:0] CFG_PPQN_SHIFT    = 2'd1;
  localparam logic [1:0] CFG_CLOCK_TIMEOUT = 2'd2;

  localparam logic [1:0]               RESET_CLOCK_MODE    = MODE_AUTO;
  localparam logic [2:0]               RESET_PPQN_SHIFT    = 3'd4;
  localparam logic [TIMEOUT_WIDTH-1:0] RESET_CLOCK_TIMEOUT = 16'd11000;

  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] MIDI_START    = 8'hFA;
  localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
  localparam logic [7:0] MIDI_STOP     = 8'hFC;
  localparam logic [7:0] MIDI_SPP      = 8'hF2;
  localparam logic [7:0] MIDI_STATUS   = 8'h80;
  localparam logic [7:0] MIDI_REALTIME = 8'hF8;

  localparam int PF_START = 0;
  localparam int PF_STOP  = 1;
  localparam int PF_CONT  = 2;
  localparam int PF_SONG  = 3;

  typedef enum logic [2:0] {
    RUN_OFF     = 3'b001,
    RUN_ARMED   = 3'b010,
    RUN_CLOCKED = 3'b100
  } run_t;

  localparam logic [1:0] RUN_CODE_OFF     = 2'd0;
  localparam logic [1:0] RUN_CODE_ARMED   = 2'd1;
  localparam logic [1:0] RUN_CODE_CLOCKED = 2'd2;

  typedef enum logic [2:0] {
    SP_IDLE = 3'b001,
    SP_LSB  = 3'b010,
    SP_MSB  = 3'b100
  } sp_t;

  typedef struct packed {
    logic                   slave_flag;
    run_t                   transport;
    logic [TICK_WIDTH-1:0]  tick_count;
    logic [REQ_WIDTH-1:0]   req_count;
    logic [3:0]             pending;
    logic [GAP_WIDTH-1:0]   gap;
    logic [GAP_WIDTH-1:0]   measured_gap;
    logic [BEAT_WIDTH-1:0]  beat_acc;
    logic [BEAT_WIDTH-1:0]  beat_latched;
    logic [SENT_WIDTH-1:0]  interp_sent;
    logic [CIB_WIDTH-1:0]   clocks_in_beat;
    logic [GAP_WIDTH-1:0]   interp_countdown;
    sp_t                    sp_state;
    logic [SONG_WIDTH-1:0]  spp_position;
  } state_t;

  localparam state_t STATE_RESET = '{
    slave_flag:       1'b0,
    transport:        RUN_OFF,
    tick_count:       '0,
    req_count:        '0,
    pending:          '0,
    gap:              '0,
    measured_gap:     '0,
    beat_acc:         '0,
    beat_latched:     '0,
    interp_sent:      '0,
    clocks_in_beat:   '0,
    interp_countdown: '0,
    sp_state:         SP_IDLE,
    spp_position:     '0
  };

  typedef struct packed {
    logic [1:0]               clock_mode;
    logic [2:0]               ppqn_shift;
    logic [TIMEOUT_WIDTH-1:0] clock_timeout;
  } cfg_t;

  typedef struct packed {
    op_t                   operation;
    logic [7:0]            rx_byte;
    logic [1:0]            host_cmd;
    logic [TICK_WIDTH-1:0] tick_value;
  } item_t;

  typedef struct packed {
    logic                  clock_valid;
    logic [TICK_WIDTH-1:0] tick_out;
    logic                  start_req;
    logic                  stop_req;
    logic                  cont_req;
    logic                  spp_req;
    logic [SONG_WIDTH-1:0] spp_value;
    logic [1:0]            run_state;
    logic                  is_master;
    logic [BEAT_WIDTH-1:0] beat_delay;
    logic                  clock_lost;
    logic                  switched_master;
  } result_t;

  function automatic logic [1:0] run_code(run_t r);
    logic [1:0] code;
    unique case (r)
      RUN_OFF:     code = RUN_CODE_OFF;
      RUN_ARMED:   code = RUN_CODE_ARMED;
      RUN_CLOCKED: code = RUN_CODE_CLOCKED;
      default:     code = RUN_CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/mcs_step.sv =====
module mcs_step
  import mcs_pkg::*;
(
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic [2:0]            sh;
  logic [SENT_WIDTH-1:0] factor;
  logic [SENT_WIDTH-1:0] add_n;
  logic                  granted;
  logic                  switched;
  logic [3:0]            flags_shown;
  logic [TICK_WIDTH-1:0] tick_shown;
  logic                  slave_eff;
  logic                  is_clk_byte;
  logic [CIB_WIDTH-1:0]  cib_inc;
  logic [SONG_WIDTH-1:0] pos_new;
  logic [SONG_WIDTH+2:0] pos_ticks;
  logic [GAP_WIDTH-1:0]  cd_dec;

  assign sh     = (cfg.ppqn_shift > 3'(SHIFT_MAX)) ? 3'(SHIFT_MAX) : cfg.ppqn_shift;
  assign factor = SENT_WIDTH'(1) << sh;

  assign is_clk_byte = (item.rx_byte == MIDI_CLOCK) ||
                       ((item.rx_byte >= MIDI_START) && (item.rx_byte <= MIDI_STOP));
  assign slave_eff   = st.slave_flag || (cfg.clock_mode == MODE_AUTO);
  assign cib_inc     = st.clocks_in_beat + CIB_WIDTH'(1);
  assign cd_dec      = st.interp_countdown - GAP_WIDTH'(1);
  assign pos_new     = st.spp_position | SONG_WIDTH'({item.rx_byte[6:0], 7'd0});
  assign pos_ticks   = pos_new * 3'd6;

  always_comb begin
    st_next  = st;
    add_n    = '0;
    granted  = 1'b0;
    switched = 1'b0;

    unique case (item.operation)
      OP_TIMER: begin
        if (!st.slave_flag) begin
          if (st.transport == RUN_CLOCKED) add_n = SENT_WIDTH'(1);
        end else begin
          if (st.gap != GAP_MAX) st_next.gap = st.gap + GAP_WIDTH'(1);
          if (st.interp_countdown != '0) begin
            st_next.interp_countdown = cd_dec;
            if (cd_dec == '0 && st.interp_sent < factor) begin
              st_next.interp_countdown = st.measured_gap >> sh;
              st_next.interp_sent      = st.interp_sent + SENT_WIDTH'(1);
              if (st.transport == RUN_CLOCKED) add_n = SENT_WIDTH'(1);
            end
          end
        end
      end

      OP_MIDI: begin
        if (is_clk_byte) begin
          st_next.slave_flag = slave_eff;
          if (slave_eff) begin
            priority case (item.rx_byte)
              MIDI_CLOCK: begin
                st_next.measured_gap = st.gap;
                if (cib_inc < CIB_WIDTH'(CLOCKS_PER_BEAT)) begin
                  st_next.clocks_in_beat = cib_inc;
                  st_next.beat_acc       = st.beat_acc + BEAT_WIDTH'(st.gap);
                end else begin
                  st_next.clocks_in_beat = '0;
                  st_next.beat_latched   = st.beat_acc;
                  st_next.beat_acc       = BEAT_WIDTH'(st.gap);
                end
                st_next.gap              = '0;
                st_next.interp_countdown = st.gap >> sh;
                // catch up on interpolated ticks not yet sent, then the clock tick itself
                if (st.transport == RUN_CLOCKED && st.interp_sent < factor)
                  add_n = factor - st.interp_sent;
                if (st.transport != RUN_OFF) begin
                  st_next.interp_sent = SENT_WIDTH'(1);
                  add_n = add_n + SENT_WIDTH'(1);
                end else begin
                  st_next.interp_sent = '0;
                end
                if (st.transport == RUN_ARMED) st_next.transport = RUN_CLOCKED;
              end
              MIDI_START: begin
                st_next.pending[PF_START] = 1'b1;
                st_next.pending[PF_STOP]  = 1'b0;
                st_next.req_count         = '0;
                st_next.interp_sent       = factor;
                st_next.clocks_in_beat    = '0;
                st_next.beat_acc          = '0;
                st_next.tick_count        = '0;
                st_next.transport         = RUN_ARMED;
              end
              MIDI_CONTINUE: begin
                st_next.pending[PF_CONT] = 1'b1;
                st_next.pending[PF_STOP] = 1'b0;
                st_next.transport        = RUN_ARMED;
              end
              default: begin
                st_next.pending[PF_STOP] = 1'b1;
                st_next.transport        = RUN_OFF;
              end
            endcase
          end
        end else begin
          unique case (st.sp_state)
            SP_IDLE: begin
              if (item.rx_byte == MIDI_SPP) st_next.sp_state = SP_LSB;
            end
            SP_LSB, SP_MSB: begin
              // real-time bytes pass through, other status bytes abort
              if (item.rx_byte >= MIDI_REALTIME) begin
                st_next.sp_state = st.sp_state;
              end else if (item.rx_byte >= MIDI_STATUS) begin
                st_next.sp_state = SP_IDLE;
              end else if (st.sp_state == SP_LSB) begin
                st_next.spp_position = SONG_WIDTH'(item.rx_byte[6:0]);
                st_next.sp_state     = SP_MSB;
              end else begin
                st_next.spp_position     = pos_new;
                st_next.sp_state         = SP_IDLE;
                st_next.pending[PF_SONG] = 1'b1;
                st_next.tick_count       = TICK_WIDTH'(pos_ticks) << sh;
              end
            end
            default: st_next.sp_state = SP_IDLE;
          endcase
        end
      end

      OP_HOST: begin
        unique case (item.host_cmd)
          HOST_START: begin
            st_next.pending[PF_START] = 1'b1;
            st_next.transport         = RUN_CLOCKED;
          end
          HOST_CONT: begin
            st_next.pending[PF_CONT] = 1'b1;
            st_next.transport        = RUN_CLOCKED;
          end
          HOST_STOP: begin
            st_next.pending[PF_STOP] = 1'b1;
            st_next.transport        = RUN_OFF;
          end
          default: ;
        endcase
      end

      OP_POLL_CLOCK: begin
        if (st.pending == '0) begin
          if (TICK_WIDTH'(st.req_count) > st.tick_count)
            st_next.tick_count = TICK_WIDTH'(st.req_count);
          if (st.req_count != '0) granted = 1'b1;
        end
      end

      OP_SET_TICK: st_next.tick_count = item.tick_value;

      OP_AUTO_CHECK: begin
        if (st.slave_flag && cfg.clock_mode == MODE_AUTO &&
            CMP_WIDTH'(st.gap) >= CMP_WIDTH'(cfg.clock_timeout)) begin
          st_next.slave_flag = 1'b0;
          switched           = 1'b1;
        end
      end

      OP_POLL_FLAGS, OP_NOP: ;

      default: ;
    endcase

    st_next.tick_count = st_next.tick_count + TICK_WIDTH'(add_n);
    st_next.req_count  = st_next.req_count + REQ_WIDTH'(add_n);

    flags_shown = st_next.pending;
    if (item.operation == OP_POLL_FLAGS) st_next.pending = '0;

    tick_shown = st_next.tick_count;
    if (granted) begin
      tick_shown        = st_next.tick_count - TICK_WIDTH'(st_next.req_count);
      st_next.req_count = st_next.req_count - REQ_WIDTH'(1);
    end

    res.clock_valid     = granted;
    res.tick_out        = tick_shown;
    res.start_req       = flags_shown[PF_START];
    res.stop_req        = flags_shown[PF_STOP];
    res.cont_req        = flags_shown[PF_CONT];
    res.spp_req         = flags_shown[PF_SONG];
    res.spp_value       = st_next.spp_position;
    res.run_state       = run_code(st_next.transport);
    res.is_master       = !st_next.slave_flag;
    res.beat_delay      = st_next.beat_latched;
    res.clock_lost      = st_next.slave_flag &&
                          (CMP_WIDTH'(st_next.gap) >= CMP_WIDTH'(cfg.clock_timeout));
    res.switched_master = switched;
  end

endmodule

// ===== rtl/midi_clock_sync_tick_generator.sv =====
// Sequencer tick generator, master on timer ticks or slave to incoming MIDI clock with
// 2^ppqn_shift (capped at 4) interpolated ticks per clock. Every accepted request yields exactly
// one result. One request is accepted per clock cycle unless in_stall is high; a request is
// registered in the item register on entry and its result in the result register. The rate rests
// on the combinational update of the sync state each request reads and rewrites. Configuration
// writes go straight into the registers and must only happen while no request is in flight.
module midi_clock_sync_tick_generator
  import mcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               operation,
  input  logic [7:0]               rx_byte,
  input  logic [1:0]               host_cmd,
  input  logic [TICK_WIDTH-1:0]    tick_value,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     clock_valid,
  output logic [TICK_WIDTH-1:0]    tick_out,
  output logic                     start_req,
  output logic                     stop_req,
  output logic                     cont_req,
  output logic                     spp_req,
  output logic [SONG_WIDTH-1:0]    spp_value,
  output logic [1:0]               run_state,
  output logic                     is_master,
  output logic [BEAT_WIDTH-1:0]    beat_delay,
  output logic                     clock_lost,
  output logic                     switched_master,

  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [TIMEOUT_WIDTH-1:0] cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  logic    item_valid;
  result_t res_next;
  result_t res;
  logic    fire;

  // the item register moves on whenever the result register can take a new result
  assign fire     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;

  mcs_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_mode    <= RESET_CLOCK_MODE;
      cfg.ppqn_shift    <= RESET_PPQN_SHIFT;
      cfg.clock_timeout <= RESET_CLOCK_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CLOCK_MODE:    cfg.clock_mode    <= cfg_data[1:0];
        CFG_PPQN_SHIFT:    cfg.ppqn_shift    <= cfg_data[2:0];
        CFG_CLOCK_TIMEOUT: cfg.clock_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (cfg_write && cfg_index == CFG_CLOCK_MODE) begin
      st.slave_flag <= (cfg_data[1:0] == MODE_SLAVE);
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.operation  <= op_t'(operation);
      item.rx_byte    <= rx_byte;
      item.host_cmd   <= host_cmd;
      item.tick_value <= tick_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res <= res_next;
  end

  assign clock_valid     = res.clock_valid;
  assign tick_out        = res.tick_out;
  assign start_req       = res.start_req;
  assign stop_req        = res.stop_req;
  assign cont_req        = res.cont_req;
  assign spp_req         = res.spp_req;
  assign spp_value       = res.spp_value;
  assign run_state       = res.run_state;
  assign is_master       = res.is_master;
  assign beat_delay      = res.beat_delay;
  assign clock_lost      = res.clock_lost;
  assign switched_master = res.switched_master;

endmodule

// ===== bench/tick_sync_checker.sv =====
module tick_sync_checker
  import mcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               operation,
  input  logic [7:0]               rx_byte,
  input  logic [1:0]               host_cmd,
  input  logic [TICK_WIDTH-1:0]    tick_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     clock_valid,
  input  logic [TICK_WIDTH-1:0]    tick_out,
  input  logic                     start_req,
  input  logic                     stop_req,
  input  logic                     cont_req,
  input  logic                     spp_req,
  input  logic [SONG_WIDTH-1:0]    spp_value,
  input  logic [1:0]               run_state,
  input  logic                     is_master,
  input  logic [BEAT_WIDTH-1:0]    beat_delay,
  input  logic                     clock_lost,
  input  logic                     switched_master,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [TIMEOUT_WIDTH-1:0] cfg_data,
  output int                       errors,
  output int                       results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 60;

  // configuration copy
  logic [1:0]               mode_reg;
  logic [2:0]               shift_reg;
  logic [TIMEOUT_WIDTH-1:0] timeout_reg;

  // sync state
  logic                  slave;
  logic [1:0]            run;
  logic [TICK_WIDTH-1:0] ticks;
  logic [REQ_WIDTH-1:0]  reqs;
  logic [3:0]            flags;
  logic [GAP_WIDTH-1:0]  gap;
  logic [GAP_WIDTH-1:0]  last_gap;
  logic [GAP_WIDTH-1:0]  countdown;
  logic [BEAT_WIDTH-1:0] beat_sum;
  logic [BEAT_WIDTH-1:0] beat_hold;
  logic [4:0]            sent;
  logic [4:0]            clocks;
  sp_t                   sp_phase;
  logic [SONG_WIDTH-1:0] song;

  result_t expected_results[$];

  function automatic logic [2:0] shift_now();
    return (shift_reg > SHIFT_MAX) ? 3'(SHIFT_MAX) : shift_reg;
  endfunction

  function automatic void add_ticks(logic [TICK_WIDTH-1:0] n);
    ticks = ticks + n;
    reqs  = reqs + n[REQ_WIDTH-1:0];
  endfunction

  function automatic void check_field(string name, logic [TICK_WIDTH-1:0] want,
                                      logic [TICK_WIDTH-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic result_t predict_result(op_t op, logic [7:0] b, logic [1:0] cmd,
                                              logic [TICK_WIDTH-1:0] val);
    result_t    r;
    logic [4:0] factor;
    logic [3:0] shown;
    logic       granted;
    logic       switched;
    factor   = 5'd1 << shift_now();
    granted  = 1'b0;
    switched = 1'b0;
    case (op)
      OP_TIMER: begin
        if (!slave) begin
          if (run == RUN_CODE_CLOCKED) add_ticks(1);
        end else begin
          if (gap != GAP_MAX) gap = gap + 1'b1;
          if (countdown != '0) begin
            countdown = countdown - 1'b1;
            if (countdown == '0 && sent < factor) begin
              countdown = last_gap >> shift_now();
              sent      = sent + 1'b1;
              if (run == RUN_CODE_CLOCKED) add_ticks(1);
            end
          end
        end
      end
      OP_MIDI: begin
        if (b == MIDI_CLOCK || (b >= MIDI_START && b <= MIDI_STOP)) begin
          if (!slave && mode_reg == MODE_AUTO) slave = 1'b1;
          if (slave) begin
            case (b)
              MIDI_CLOCK: begin
                last_gap = gap;
                clocks   = clocks + 1'b1;
                if (clocks < CLOCKS_PER_BEAT) begin
                  beat_sum = beat_sum + BEAT_WIDTH'(gap);
                end else begin
                  clocks    = '0;
                  beat_hold = beat_sum;
                  beat_sum  = BEAT_WIDTH'(gap);
                end
                gap       = '0;
                countdown = last_gap >> shift_now();
                // catch up on interpolated ticks the last gap did not deliver
                if (run == RUN_CODE_CLOCKED && sent < factor)
                  add_ticks(TICK_WIDTH'(factor - sent));
                if (run != RUN_CODE_OFF) begin
                  sent = 5'd1;
                  add_ticks(1);
                end else begin
                  sent = '0;
                end
                if (run == RUN_CODE_ARMED) run = RUN_CODE_CLOCKED;
              end
              MIDI_START: begin
                flags[PF_START] = 1'b1;
                flags[PF_STOP]  = 1'b0;
                reqs            = '0;
                sent            = factor;
                clocks          = '0;
                beat_sum        = '0;
                ticks           = '0;
                run             = RUN_CODE_ARMED;
              end
              MIDI_CONTINUE: begin
                flags[PF_CONT] = 1'b1;
                flags[PF_STOP] = 1'b0;
                run            = RUN_CODE_ARMED;
              end
              default: begin
                flags[PF_STOP] = 1'b1;
                run            = RUN_CODE_OFF;
              end
            endcase
          end
        end else if (sp_phase == SP_IDLE) begin
          if (b == MIDI_SPP) sp_phase = SP_LSB;
        end else if (b < MIDI_REALTIME) begin
          if (b >= MIDI_STATUS) begin
            sp_phase = SP_IDLE;
          end else if (sp_phase == SP_LSB) begin
            song     = SONG_WIDTH'(b);
            sp_phase = SP_MSB;
          end else begin
            song            = song | (SONG_WIDTH'(b) << 7);
            sp_phase        = SP_IDLE;
            flags[PF_SONG]  = 1'b1;
            ticks           = TICK_WIDTH'(song) * (TICK_WIDTH'(6) << shift_now());
          end
        end
      end
      OP_HOST: begin
        case (cmd)
          HOST_START: begin
            flags[PF_START] = 1'b1;
            run             = RUN_CODE_CLOCKED;
          end
          HOST_CONT: begin
            flags[PF_CONT] = 1'b1;
            run            = RUN_CODE_CLOCKED;
          end
          HOST_STOP: begin
            flags[PF_STOP] = 1'b1;
            run            = RUN_CODE_OFF;
          end
          default: ;
        endcase
      end
      OP_POLL_CLOCK: begin
        // held back while any request flag is pending
        if (flags == '0) begin
          if (TICK_WIDTH'(reqs) > ticks) ticks = TICK_WIDTH'(reqs);
          granted = (reqs != '0);
        end
      end
      OP_SET_TICK: ticks = val;
      OP_AUTO_CHECK: begin
        if (slave && mode_reg == MODE_AUTO && gap >= timeout_reg) begin
          slave    = 1'b0;
          switched = 1'b1;
        end
      end
      default: ;
    endcase

    shown = flags;
    if (op == OP_POLL_FLAGS) flags = '0;

    r.clock_valid     = granted;
    r.tick_out        = granted ? ticks - TICK_WIDTH'(reqs) : ticks;
    if (granted) reqs = reqs - 1'b1;
    r.start_req       = shown[PF_START];
    r.stop_req        = shown[PF_STOP];
    r.cont_req        = shown[PF_CONT];
    r.spp_req         = shown[PF_SONG];
    r.spp_value       = song;
    r.run_state       = run;
    r.is_master       = !slave;
    r.beat_delay      = beat_hold;
    r.clock_lost      = slave && gap >= timeout_reg;
    r.switched_master = switched;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mode_reg    = RESET_CLOCK_MODE;
      shift_reg   = RESET_PPQN_SHIFT;
      timeout_reg = RESET_CLOCK_TIMEOUT;
      slave       = (RESET_CLOCK_MODE == MODE_SLAVE);
      run         = RUN_CODE_OFF;
      ticks       = '0;
      reqs        = '0;
      flags       = '0;
      gap         = '0;
      last_gap    = '0;
      countdown   = '0;
      beat_sum    = '0;
      beat_hold   = '0;
      sent        = '0;
      clocks      = '0;
      sp_phase    = SP_IDLE;
      song        = '0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CLOCK_MODE: begin
            mode_reg = cfg_data[1:0];
            slave    = (mode_reg == MODE_SLAVE);
          end
          CFG_PPQN_SHIFT:    shift_reg   = cfg_data[2:0];
          CFG_CLOCK_TIMEOUT: timeout_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no request outstanding, expected none, got tick %0h",
                     $time, tick_out);
        end else begin
          want = expected_results.pop_front();
          check_field("clock_valid", want.clock_valid, clock_valid);
          check_field("tick_out", want.tick_out, tick_out);
          check_field("start_req", want.start_req, start_req);
          check_field("stop_req", want.stop_req, stop_req);
          check_field("cont_req", want.cont_req, cont_req);
          check_field("spp_req", want.spp_req, spp_req);
          check_field("spp_value", want.spp_value, spp_value);
          check_field("run_state", want.run_state, run_state);
          check_field("is_master", want.is_master, is_master);
          check_field("beat_delay", want.beat_delay, beat_delay);
          check_field("clock_lost", want.clock_lost, clock_lost);
          check_field("switched_master", want.switched_master, switched_master);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(op_t'(operation), rx_byte, host_cmd,
                                                  tick_value));
    end
    results_owed <= expected_results.size();
  end

endmodule

// ===== bench/midi_clock_sync_tick_generator_test.sv =====
module midi_clock_sync_tick_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcs_pkg::*;

  localparam int         IDLE_LIMIT   = 500;
  localparam int         DRAIN_CYCLES = 4;
  localparam int         PHASE_ITEMS  = 30;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] HOST_UNUSED  = 2'd3;
  localparam logic [7:0] MIDI_SENSING = 8'hFE;
  localparam logic [7:0] MIDI_DATA_MAX = 8'h7F;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [2:0]               operation  = '0;
  logic [7:0]               rx_byte    = '0;
  logic [1:0]               host_cmd   = '0;
  logic [TICK_WIDTH-1:0]    tick_value = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     clock_valid;
  logic [TICK_WIDTH-1:0]    tick_out;
  logic                     start_req;
  logic                     stop_req;
  logic                     cont_req;
  logic                     spp_req;
  logic [SONG_WIDTH-1:0]    spp_value;
  logic [1:0]               run_state;
  logic                     is_master;
  logic [BEAT_WIDTH-1:0]    beat_delay;
  logic                     clock_lost;
  logic                     switched_master;

  logic                     cfg_write = 1'b0;
  logic [1:0]               cfg_index = '0;
  logic [TIMEOUT_WIDTH-1:0] cfg_data  = '0;

  int errors;
  int results_owed;
  int requests_sent = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  bit steady        = 1'b0;  // no idling on either side while set

  midi_clock_sync_tick_generator dut (.*);
  tick_sync_checker checker_i (.*);

  always #1 clk = ~clk;

  function automatic int pick_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = pick_wait();
    else if (stall_left > 0) stall_left--;
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("midi_clock_sync_tick_generator_test: errors");
        $finish;
      end
    end
  end

  task automatic send(op_t op, logic [7:0] b, logic [1:0] cmd, logic [TICK_WIDTH-1:0] val);
    int idle;
    idle = pick_wait();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    rx_byte    <= b;
    host_cmd   <= cmd;
    tick_value <= val;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic plain(op_t op);
    send(op, 8'($urandom), 2'($urandom), $urandom);
  endtask

  task automatic midi(logic [7:0] b);
    send(OP_MIDI, b, 2'($urandom), $urandom);
  endtask

  task automatic host(logic [1:0] cmd);
    send(OP_HOST, 8'($urandom), cmd, $urandom);
  endtask

  task automatic set_tick(logic [TICK_WIDTH-1:0] val);
    send(OP_SET_TICK, 8'($urandom), 2'($urandom), val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [TIMEOUT_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] mode, logic [2:0] shift, logic [TIMEOUT_WIDTH-1:0] lim);
    drain();
    write_reg(CFG_CLOCK_MODE, TIMEOUT_WIDTH'(mode));
    write_reg(CFG_PPQN_SHIFT, TIMEOUT_WIDTH'(shift));
    write_reg(CFG_CLOCK_TIMEOUT, lim);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(int budget);
    int                    stop_at;
    int                    g;
    logic [TICK_WIDTH-1:0] val;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // clock train: timer ticks between F8 bytes, polls sprinkled in
          repeat ($urandom_range(1, 4)) begin
            g = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            repeat (g) begin
              plain(OP_TIMER);
              if ($urandom_range(0, 3) == 0) plain(OP_POLL_CLOCK);
            end
            midi(MIDI_CLOCK);
          end
        end
        3: begin
          case ($urandom_range(0, 5))
            0: midi(MIDI_START);
            1: midi(MIDI_CONTINUE);
            2: midi(MIDI_STOP);
            3: host(HOST_START);
            4: host(HOST_CONT);
            default: host(2'($urandom));
          endcase
          if ($urandom_range(0, 3) != 0) plain(OP_POLL_FLAGS);
        end
        4: begin
          midi(MIDI_SPP);
          if ($urandom_range(0, 4) == 0) midi(8'($urandom_range(MIDI_REALTIME, 255)));
          if ($urandom_range(0, 5) == 0) midi(8'($urandom_range(MIDI_STATUS, 247)));
          midi(8'($urandom_range(0, MIDI_DATA_MAX)));
          midi(8'($urandom_range(0, MIDI_DATA_MAX)));
          if ($urandom_range(0, 1) == 0) plain(OP_POLL_FLAGS);
        end
        5: begin
          plain(OP_POLL_FLAGS);
          repeat ($urandom_range(1, 6)) plain(OP_POLL_CLOCK);
        end
        6: begin
          val = $urandom;
          if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 1) ? '1 : '0;
          set_tick(val);
        end
        7: plain(OP_AUTO_CHECK);
        default: send(op_t'($urandom_range(0, 7)), 8'($urandom), 2'($urandom), $urandom);
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset configuration (auto mode)
    plain(OP_NOP);
    plain(OP_POLL_CLOCK);
    host(HOST_UNUSED);
    host(HOST_START);
    plain(OP_TIMER);
    plain(OP_POLL_CLOCK);
    plain(OP_POLL_FLAGS);
    plain(OP_POLL_CLOCK);
    set_tick('1);
    plain(OP_TIMER);
    set_tick('0);
    midi(MIDI_SPP);
    midi(MIDI_DATA_MAX);
    midi(MIDI_DATA_MAX);
    // real-time byte inside a song position is skipped
    midi(MIDI_SPP);
    midi(MIDI_SENSING);
    midi(8'h00);
    midi(8'h01);
    // other status byte aborts the parse
    midi(MIDI_SPP);
    midi(MIDI_STATUS);
    midi(8'hFF);
    host(HOST_CONT);
    host(HOST_STOP);
    midi(MIDI_CLOCK);
    midi(MIDI_START);
    plain(OP_TIMER);
    midi(MIDI_CLOCK);
    plain(OP_AUTO_CHECK);

    configure(MODE_AUTO, RESET_PPQN_SHIFT, RESET_CLOCK_TIMEOUT);
    random_phase(PHASE_ITEMS);
    configure(MODE_SLAVE, 3'd0, '0);
    random_phase(PHASE_ITEMS);
    configure(MODE_SLAVE, 3'd4, 16'd20);
    random_phase(PHASE_ITEMS);
    configure(MODE_MASTER, 3'd2, '1);
    random_phase(PHASE_ITEMS);
    configure(MODE_UNUSED, 3'd7, 16'd5);
    random_phase(PHASE_ITEMS);
    configure(MODE_AUTO, 3'd5, 16'd30);
    random_phase(PHASE_ITEMS);
    configure(MODE_SLAVE, 3'd6, 16'd40);
    random_phase(PHASE_ITEMS);
    configure(MODE_AUTO, 3'd1, '0);
    random_phase(PHASE_ITEMS);
    configure(MODE_SLAVE, 3'd3, 16'($urandom_range(1, 100)));
    random_phase(PHASE_ITEMS);

    // full beat of short gaps, then a long quiet stretch
    configure(MODE_AUTO, RESET_PPQN_SHIFT, '1);
    steady = 1'b1;
    midi(MIDI_CLOCK);
    midi(MIDI_START);
    plain(OP_POLL_FLAGS);
    repeat (CLOCKS_PER_BEAT + 2) begin
      repeat (2) plain(OP_TIMER);
      midi(MIDI_CLOCK);
    end
    repeat (40) plain(OP_TIMER);
    plain(OP_AUTO_CHECK);
    midi(MIDI_CLOCK);
    repeat (20) plain(OP_TIMER);
    plain(OP_POLL_CLOCK);
    steady = 1'b0;

    drain();
    if (errors == 0) begin
      $display("midi_clock_sync_tick_generator_test: clean");
    end else begin
      $display("midi_clock_sync_tick_generator_test: errors");
    end
    $finish;
  end

endmodule
